// ===== src/pwcf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwcf_pkg
// Shared types and constants for the port-write capture to frames core.
// ----------------------------------------------------------------------------
package pwcf_pkg;

  localparam int unsigned FRAME_W    = 18;
  localparam int unsigned ACC_W      = 32;
  localparam int unsigned STAMP_W    = 16;
  localparam int unsigned PORT_W     = 16;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned ENDS_W     = 6;

  localparam logic [FRAME_W-1:0] FRAME_RESET  = 18'd69888;
  localparam logic [FRAME_W-1:0] FRAME_MIN    = 18'd1024;
  localparam logic [ENDS_W-1:0]  MAX_ENDS     = 6'd32;
  localparam logic signed [STAMP_W-1:0] WRAP_TICKS = 16'sd17472;

  localparam logic [PORT_W-1:0] PORT_MASK = 16'hC002;
  localparam logic [PORT_W-1:0] SEL_PORT  = 16'hFFFD;
  localparam logic [PORT_W-1:0] DATA_PORT = 16'hBFFD;
  localparam logic [STAMP_W-1:0] MARKER_STAMP = 16'hFFFF;

  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FRAME = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd2;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_SEL  = 2'd1,
    ACT_DATA = 2'd2
  } act_t;

  typedef struct packed {
    logic signed [STAMP_W-1:0] delta;
    act_t                      act;
    logic [BYTE_W-1:0]         value;
  } entry_t;

endpackage

// ===== src/pwcf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwcf_front
// Accepts capture records, forms the wrapped stamp delta and decodes the port.
// ----------------------------------------------------------------------------
module pwcf_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [pwcf_pkg::STAMP_W-1:0] stamp,
  input  logic        [pwcf_pkg::PORT_W-1:0]  port_number,
  input  logic        [pwcf_pkg::BYTE_W-1:0]  port_byte,
  input  logic                                q_full,
  output logic                                q_push,
  output pwcf_pkg::entry_t                    q_entry
);
  import pwcf_pkg::*;

  logic [STAMP_W-1:0]        prev_stamp;
  logic                      marker;
  logic [STAMP_W-1:0]        cur;
  logic signed [STAMP_W-1:0] diff;
  logic [PORT_W-1:0]         dec;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    marker = (stamp == MARKER_STAMP);
    cur    = marker ? '0 : stamp;
    diff   = $signed(cur - prev_stamp);
    dec    = port_number & PORT_MASK;
    q_entry.delta = (diff <= 0) ? diff + WRAP_TICKS : diff;
    q_entry.value = port_byte;
    if (marker) begin
      q_entry.act = ACT_NONE;
    end else if (dec == (SEL_PORT & PORT_MASK)) begin
      q_entry.act = ACT_SEL;
    end else if (dec == (DATA_PORT & PORT_MASK)) begin
      q_entry.act = ACT_DATA;
    end else begin
      q_entry.act = ACT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_stamp <= '0;
    end else if (q_push) begin
      prev_stamp <= cur;
    end
  end

endmodule

// ===== src/pwcf_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwcf_queue
// Two-entry queue of decoded records between front and back.
// ----------------------------------------------------------------------------
module pwcf_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  pwcf_pkg::entry_t push_entry,
  input  logic             pop,
  output pwcf_pkg::entry_t head,
  output logic             full,
  output logic             empty
);
  import pwcf_pkg::*;

  entry_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== src/pwcf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwcf_back
// Accumulates t-states, emits frame ends one per cycle while out_stall allows, then the port action.
// ----------------------------------------------------------------------------
module pwcf_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic        [pwcf_pkg::FRAME_W-1:0] cfg_wr_data,
  input  logic                               q_empty,
  input  pwcf_pkg::entry_t                   q_head,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic        [pwcf_pkg::KIND_W-1:0] kind,
  output logic        [pwcf_pkg::BYTE_W-1:0] reg_index,
  output logic        [pwcf_pkg::BYTE_W-1:0] reg_value,
  output logic                               last
);
  import pwcf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t                  state;
  logic [FRAME_W-1:0]      frame;
  logic signed [ACC_W-1:0] acc;
  logic [BYTE_W-1:0]       selected_reg;
  logic [ENDS_W-1:0]       ends;
  act_t                    act;
  logic [BYTE_W-1:0]       value;

  logic signed [ACC_W:0]   sum;
  logic signed [ACC_W-1:0] acc_sum;
  logic signed [ACC_W-1:0] acc_sub;
  logic signed [ACC_W-1:0] frame_s;
  logic                    more_frames;
  logic                    slot_free;
  logic                    emit;
  logic [KIND_W-1:0]       emit_kind;
  logic [BYTE_W-1:0]       emit_idx;
  logic [BYTE_W-1:0]       emit_val;
  logic                    emit_last;
  logic                    run_step;

  assign slot_free = !out_valid || !out_stall;
  assign q_pop     = (state == S_IDLE) && !q_empty;
  assign run_step  = (state == S_RUN) && slot_free;

  always_comb begin
    frame_s     = $signed({{(ACC_W-FRAME_W){1'b0}}, frame});
    sum         = {acc[ACC_W-1], acc} + {{(ACC_W+1-STAMP_W){q_head.delta[STAMP_W-1]}},
                                         q_head.delta};
    acc_sum     = (sum[ACC_W:ACC_W-1] == 2'b10) ? {1'b1, {(ACC_W-1){1'b0}}}
                                                 : sum[ACC_W-1:0];
    acc_sub     = acc - frame_s;
    more_frames = (acc >= frame_s) && (ends < MAX_ENDS);
    emit      = 1'b0;
    emit_kind = KIND_NONE;
    emit_idx  = '0;
    emit_val  = '0;
    emit_last = 1'b1;
    if (state == S_RUN) begin
      if (more_frames) begin
        emit      = 1'b1;
        emit_kind = KIND_FRAME;
        emit_last = !((acc_sub >= frame_s) && (ends != MAX_ENDS - 6'd1)) &&
                    (act != ACT_DATA);
      end else if (act == ACT_DATA) begin
        emit      = 1'b1;
        emit_kind = KIND_WRITE;
        emit_idx  = selected_reg;
        emit_val  = value;
      end else if (ends == '0) begin
        emit      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame <= FRAME_RESET;
    end else if (cfg_wr_en) begin
      frame <= (cfg_wr_data < FRAME_MIN) ? FRAME_MIN : cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      acc          <= '0;
      selected_reg <= '0;
      ends         <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            acc   <= acc_sum;
            ends  <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (run_step) begin
            if (more_frames) begin
              acc  <= acc_sub;
              ends <= ends + 6'd1;
            end else begin
              if (act == ACT_SEL) begin
                selected_reg <= value;
              end
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      act   <= q_head.act;
      value <= q_head.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      kind      <= emit_kind;
      reg_index <= emit_idx;
      reg_value <= emit_val;
      last      <= emit_last;
    end
  end

  a_ends_bound: assert property (@(posedge clk) disable iff (rst)
    ends <= MAX_ENDS)
    else $error("frame end count above limit");

  a_none_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_NONE) |-> last && (reg_index == '0) && (reg_value == '0))
    else $error("no-action result not final or not cleared");

  a_write_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_WRITE) |-> last)
    else $error("register write not final result");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == KIND_NONE) || (kind == KIND_FRAME) || (kind == KIND_WRITE))
    else $error("illegal result kind");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == S_RUN))
    else $error("record taken without starting run");

endmodule

// ===== src/port_write_capture_to_frames_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// port_write_capture_to_frames_core
// Turns captured port-write records into frame ends and register writes.
// ----------------------------------------------------------------------------
//  Channel  | Handshake               | Payload
//  ---------+-------------------------+---------------------------------------
//  in       | in_valid / in_stall     | stamp, port_number, port_byte
//  out      | out_valid / out_stall   | kind, reg_index, reg_value, last
//  cfg      | cfg_wr_en               | cfg_wr_data (frame length)
//
//  A record is taken while the back is idle; its frame ends go out in turn,
//  then its port action. The back sequencer holds one record at a time.
//  A two-entry queue lets the front accept records while the back works.
//  Reset clears the stamp, accumulator and selected register and sets the
//  frame length to 69888. Out stall holds the output register and the back.
// ----------------------------------------------------------------------------
module port_write_capture_to_frames_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic        [pwcf_pkg::FRAME_W-1:0] cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [pwcf_pkg::STAMP_W-1:0] stamp,
  input  logic        [pwcf_pkg::PORT_W-1:0]  port_number,
  input  logic        [pwcf_pkg::BYTE_W-1:0]  port_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic        [pwcf_pkg::KIND_W-1:0]  kind,
  output logic        [pwcf_pkg::BYTE_W-1:0]  reg_index,
  output logic        [pwcf_pkg::BYTE_W-1:0]  reg_value,
  output logic                                last
);
  import pwcf_pkg::*;

  logic   q_push;
  logic   q_pop;
  logic   q_full;
  logic   q_empty;
  entry_t q_entry;
  entry_t q_head;

  pwcf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .stamp       (stamp),
    .port_number (port_number),
    .port_byte   (port_byte),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (q_entry)
  );

  pwcf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .full       (q_full),
    .empty      (q_empty)
  );

  pwcf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .reg_index   (reg_index),
    .reg_value   (reg_value),
    .last        (last)
  );

endmodule

// ===== tb/frame_write_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_write_checker
// Watches the record and result channels of the core. It keeps its own copy
// of the stamp, tick accumulator, selected register and frame length. It
// predicts the frame ends and register writes that each accepted record
// causes, then compares every result transfer field by field.
// ----------------------------------------------------------------------------
module frame_write_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic        [pwcf_pkg::FRAME_W-1:0] cfg_wr_data,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic signed [pwcf_pkg::STAMP_W-1:0] stamp,
  input  logic        [pwcf_pkg::PORT_W-1:0]  port_number,
  input  logic        [pwcf_pkg::BYTE_W-1:0]  port_byte,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic        [pwcf_pkg::KIND_W-1:0]  kind,
  input  logic        [pwcf_pkg::BYTE_W-1:0]  reg_index,
  input  logic        [pwcf_pkg::BYTE_W-1:0]  reg_value,
  input  logic                                last,
  output int unsigned                         pending,
  output int unsigned                         fail_count
);
  import pwcf_pkg::*;

  localparam longint ACC_FLOOR = -64'sd2147483648;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] idx;
    logic [BYTE_W-1:0] val;
    logic              last;
  } frame_result_t;

  frame_result_t         frame_results_q[$];
  logic [STAMP_W-1:0]    last_stamp;
  logic signed [ACC_W-1:0] tick_acc;
  logic [BYTE_W-1:0]     chip_reg;
  logic [FRAME_W-1:0]    frame_len;

  task automatic report_mismatch(input string what);
    $display("%0t ns: %s", $time, what);
    fail_count++;
  endtask

  task automatic predict_frames_and_writes(input logic [STAMP_W-1:0] raw,
                                           input logic [PORT_W-1:0] port,
                                           input logic [BYTE_W-1:0] data);
    logic               marker;
    logic [STAMP_W-1:0] cur;
    logic [STAMP_W-1:0] diff;
    logic [PORT_W-1:0]  dec;
    longint             step_ticks;
    longint             acc;
    longint             len;
    int                 ends;
    frame_result_t      r;
    marker = (raw == MARKER_STAMP);
    cur = marker ? '0 : raw;
    diff = cur - last_stamp;
    last_stamp = cur;
    step_ticks = longint'($signed(diff));
    if (step_ticks <= 0) begin
      step_ticks += longint'(WRAP_TICKS);
    end
    acc = longint'(tick_acc) + step_ticks;
    if (acc < ACC_FLOOR) begin
      acc = ACC_FLOOR;
    end
    len = longint'((frame_len < FRAME_MIN) ? FRAME_MIN : frame_len);
    ends = 0;
    while (acc >= len && ends < int'(MAX_ENDS)) begin
      acc -= len;
      r = '{KIND_FRAME, 8'd0, 8'd0, 1'b0};
      frame_results_q.push_back(r);
      ends++;
    end
    tick_acc = acc[ACC_W-1:0];
    if (!marker) begin
      dec = port & PORT_MASK;
      if (dec == (SEL_PORT & PORT_MASK)) begin
        chip_reg = data;
      end else if (dec == (DATA_PORT & PORT_MASK)) begin
        r = '{KIND_WRITE, chip_reg, data, 1'b0};
        frame_results_q.push_back(r);
        ends++;
      end
    end
    if (ends == 0) begin
      r = '{KIND_NONE, 8'd0, 8'd0, 1'b0};
      frame_results_q.push_back(r);
    end
    r = frame_results_q.pop_back();
    r.last = 1'b1;
    frame_results_q.push_back(r);
  endtask

  always @(posedge clk) begin : watch
    frame_result_t got;
    frame_result_t want;
    if (rst) begin
      last_stamp = '0;
      tick_acc = '0;
      chip_reg = '0;
      frame_len = FRAME_RESET;
      fail_count = 0;
      frame_results_q.delete();
    end else begin
      if (cfg_wr_en) begin
        frame_len = cfg_wr_data;
      end
      if (out_valid && !out_stall) begin
        got = '{kind, reg_index, reg_value, last};
        if (frame_results_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result transfer kind %0d", got.kind));
        end else begin
          want = frame_results_q.pop_front();
          if (got.kind !== want.kind) begin
            report_mismatch($sformatf("kind got %0d want %0d", got.kind, want.kind));
          end
          if (got.idx !== want.idx) begin
            report_mismatch($sformatf("reg_index got %0h want %0h", got.idx, want.idx));
          end
          if (got.val !== want.val) begin
            report_mismatch($sformatf("reg_value got %0h want %0h", got.val, want.val));
          end
          if (got.last !== want.last) begin
            report_mismatch($sformatf("last got %0b want %0b", got.last, want.last));
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_frames_and_writes(stamp, port_number, port_byte);
      end
    end
    pending <= frame_results_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives port-write records into the capture-to-frames core under random
// gaps and output stalls, steps the frame length through its extremes
// between phases, and reports the verdict from the frame/write checker.
// ----------------------------------------------------------------------------
module tb_top;
  import pwcf_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned PHASES         = 5;
  localparam int unsigned PHASE_RECORDS  = 17;

  logic                      clk;
  logic                      rst;
  logic                      cfg_wr_en;
  logic        [FRAME_W-1:0] cfg_wr_data;
  logic                      in_valid;
  logic                      in_stall;
  logic signed [STAMP_W-1:0] stamp;
  logic        [PORT_W-1:0]  port_number;
  logic        [BYTE_W-1:0]  port_byte;
  logic                      out_valid;
  logic                      out_stall;
  logic        [KIND_W-1:0]  kind;
  logic        [BYTE_W-1:0]  reg_index;
  logic        [BYTE_W-1:0]  reg_value;
  logic                      last;
  int unsigned               pending;
  int unsigned               fail_count;
  int unsigned               idle_cycles;
  logic        [STAMP_W-1:0] run_stamp;
  bit                        quiet;

  port_write_capture_to_frames_core u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .stamp       (stamp),
    .port_number (port_number),
    .port_byte   (port_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .reg_index   (reg_index),
    .reg_value   (reg_value),
    .last        (last)
  );

  frame_write_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .stamp       (stamp),
    .port_number (port_number),
    .port_byte   (port_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .reg_index   (reg_index),
    .reg_value   (reg_value),
    .last        (last),
    .pending     (pending),
    .fail_count  (fail_count)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: stall a random number of cycles, then take one transfer
  initial begin
    int unsigned hold;
    out_stall = 1'b1;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 16);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  task automatic send_record(input logic [STAMP_W-1:0] s, input logic [PORT_W-1:0] p,
                             input logic [BYTE_W-1:0] b);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    stamp       <= s;
    port_number <= p;
    port_byte   <= b;
    in_valid    <= 1'b1;
    run_stamp = (s == MARKER_STAMP) ? '0 : s;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic set_frame_len(input logic [FRAME_W-1:0] v);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // mostly rising stamps on select/data ports, some markers and raw noise
  task automatic send_traffic_record();
    int unsigned        pick;
    logic [STAMP_W-1:0] s;
    logic [PORT_W-1:0]  p;
    logic [BYTE_W-1:0]  b;
    pick = $urandom_range(0, 99);
    b = BYTE_W'($urandom_range(0, 255));
    p = PORT_W'($urandom);
    if (pick < 8) begin
      s = MARKER_STAMP;
    end else if (pick < 20) begin
      s = STAMP_W'($urandom);
    end else begin
      s = run_stamp + STAMP_W'($urandom_range(0, (pick < 32) ? 32767 : 6000));
      p = (p & ~PORT_MASK) |
          ((pick % 3 == 0) ? (SEL_PORT & PORT_MASK) : (DATA_PORT & PORT_MASK));
    end
    send_record(s, p, b);
  endtask

  initial begin
    logic [FRAME_W-1:0] len;
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    stamp       = '0;
    port_number = '0;
    port_byte   = '0;
    run_stamp   = '0;
    quiet       = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_record(16'h0000, SEL_PORT, 8'h07);
    send_record(16'h7FFF, DATA_PORT, 8'hFF);
    send_record(16'h8000, 16'h0000, 8'h00);
    send_record(MARKER_STAMP, DATA_PORT, 8'hAA);
    send_record(16'h7FFF, 16'hC000, 8'hFF);
    send_record(16'hFFFE, 16'h8000, 8'h00);
    send_record(16'hFFFE, 16'hFFFF, 8'h5A);
    send_record(16'h7FFD, 16'h0002, 8'h01);
    send_record(16'h7FFD, 16'h4000, 8'h80);

    set_frame_len(18'h3FFFF);
    for (int i = 0; i < 10; i++) begin
      send_record(run_stamp + 16'h7FFF, DATA_PORT, 8'(i));
    end

    // drop the frame length below its floor
    set_frame_len(18'h00000);
    for (int i = 0; i < 4; i++) begin
      send_record(run_stamp + 16'h7FFF, DATA_PORT, 8'(8'hF0 + i));
    end
    set_frame_len(18'd1023);
    send_record(run_stamp + 16'h1000, SEL_PORT, 8'h0D);
    send_record(run_stamp + 16'h1000, DATA_PORT, 8'h3C);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: len = FRAME_MIN;
        1: len = FRAME_W'($urandom);
        2: len = 18'h3FFFF;
        3: len = FRAME_W'($urandom_range(1024, 8000));
        default: len = FRAME_RESET;
      endcase
      set_frame_len(len);
      quiet = (ph == 3);
      for (int i = 0; i < PHASE_RECORDS; i++) begin
        send_traffic_record();
      end
    end
    quiet = 1'b0;

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== port_write_capture_to_frames_core.f =====
src/pwcf_pkg.sv
src/pwcf_front.sv
src/pwcf_queue.sv
src/pwcf_back.sv
src/port_write_capture_to_frames_core.sv
tb/frame_write_checker.sv
tb/tb_top.sv
